@@ sv/lpd_pkg.sv @@
// lpd_pkg: shared constants for the length-prefix deframer
// register map, field widths and framing phase codes
// no dependencies
package lpd_pkg;

    localparam int MAX_LEN_W = 22;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 22'd2097152;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MAX_LEN = 1'b0;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DROP    = 2'd2;

endpackage

@@ sv/lpd_if.sv @@
// lpd_in_if / lpd_out_if: valid/ready word channels of the deframer
// no dependencies
interface lpd_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface lpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_in_packet;
    logic       length_error;

    modport source (output valid, output payload_byte, output last_in_packet,
                    output length_error, input ready);
    modport sink   (input valid, input payload_byte, input last_in_packet,
                    input length_error, output ready);
endinterface

@@ sv/lpd_apb_regs.sv @@
// lpd_apb_regs: apb register file holding the maximum packet length
// depends on lpd_pkg
module lpd_apb_regs
    import lpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [MAX_LEN_W-1:0]  max_len
);

    logic [MAX_LEN_W-1:0] max_len_reg;
    logic [MAX_LEN_W-1:0] max_len_next;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // word index is paddr[2], byte offset bits ignored
    always_comb
    begin
        max_len_next = max_len_reg;
        if (wr_en && (paddr[2] == REG_MAX_LEN))
        begin
            max_len_next = pwdata[MAX_LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MAX_LEN)
        begin
            prdata = APB_DATA_W'(max_len_reg);
        end
    end

    assign max_len = max_len_reg;

endmodule

@@ sv/length_prefix_deframer_core.sv @@
// length_prefix_deframer_core: streaming deframer for length-prefixed packets
// depends on lpd_pkg, lpd_in_if / lpd_out_if and lpd_apb_regs
//
// Takes one received byte per word on in_ch and strips a little-endian length
// header of HEADER_BYTES bytes (least significant first) from the front of
// each packet. Payload bytes then stream out on out_ch one per word, the final
// one marked with last_in_packet. A header holding zero, or a length above the
// max_packet_length register (apb byte address 0, reset 2097152), yields one
// word with length_error set and payload_byte/last_in_packet zero; after that
// all bytes are dropped until a word with mode = 1 (new connection) arrives,
// which resets the framing state and produces nothing. Header bytes and
// dropped bytes produce no output word. Throughput is one input word per clock
// while out_ch is not stalled: each word is held in an input register,
// processed by a single level of header/payload logic and written to an output
// register. in_ch.ready stays high while the output register is empty or being
// drained, so both sides can stall independently.
// The register should only be written while no bytes are in flight.
module length_prefix_deframer_core
    import lpd_pkg::*;
#(
    parameter int HEADER_BYTES = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lpd_in_if.sink                in_ch,
    lpd_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LEN_W = 8 * HEADER_BYTES;

    // configuration
    logic [MAX_LEN_W-1:0] max_len;

    lpd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    // input register
    logic       in_vld_reg;
    logic       in_mode_reg;
    logic [7:0] in_byte_reg;
    logic       advance;

    // framing state
    logic [1:0]           phase_reg;
    logic [1:0]           phase_next;
    logic [1:0]           hdr_idx_reg;
    logic [1:0]           hdr_idx_next;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     len_next;
    logic [MAX_LEN_W-1:0] left_reg;
    logic [MAX_LEN_W-1:0] left_next;

    // output register
    logic       out_vld_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_err_reg;

    // per-word result
    logic             produce;
    logic [7:0]       res_byte;
    logic             res_last;
    logic             res_err;
    logic [LEN_W-1:0] len_full;
    logic [31:0]      len32;
    logic [MAX_LEN_W-1:0] left_dec;

    // the output side can take a new result when empty or draining
    assign advance     = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !in_vld_reg || advance;

    // header byte merged into the length at the current header position
    always_comb
    begin
        len_full = len_reg;
        for (int k = 0; k < HEADER_BYTES; k++)
        begin
            if (hdr_idx_reg == 2'(k))
            begin
                len_full[8*k +: 8] = len_reg[8*k +: 8] | in_byte_reg;
            end
        end
    end

    assign len32    = 32'(len_full);
    assign left_dec = left_reg - 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        len_next     = len_reg;
        left_next    = left_reg;
        produce      = 1'b0;
        res_byte     = 8'd0;
        res_last     = 1'b0;
        res_err      = 1'b0;
        if (in_mode_reg)
        begin
            // new connection clears all framing
            phase_next   = PH_HEADER;
            hdr_idx_next = 2'd0;
            len_next     = '0;
            left_next    = '0;
        end
        else if (phase_reg == PH_DROP)
        begin
            // bytes after a bad header are discarded
        end
        else if (phase_reg == PH_PAYLOAD)
        begin
            left_next = left_dec;
            produce   = 1'b1;
            res_byte  = in_byte_reg;
            res_last  = (left_dec == '0);
            if (left_dec == '0)
            begin
                phase_next   = PH_HEADER;
                hdr_idx_next = 2'd0;
                len_next     = '0;
            end
        end
        else
        begin
            // header phase; the unused phase code behaves the same
            len_next = len_full;
            if (32'(hdr_idx_reg) + 32'd1 < 32'(HEADER_BYTES))
            begin
                hdr_idx_next = hdr_idx_reg + 2'd1;
                phase_next   = PH_HEADER;
            end
            else
            begin
                hdr_idx_next = 2'd0;
                if ((len32 == 32'd0) || (len32 > 32'(max_len)))
                begin
                    phase_next = PH_DROP;
                    produce    = 1'b1;
                    res_err    = 1'b1;
                end
                else
                begin
                    left_next  = len32[MAX_LEN_W-1:0];
                    phase_next = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= PH_HEADER;
            hdr_idx_reg <= 2'd0;
            len_reg     <= '0;
            left_reg    <= '0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_vld_reg <= in_ch.valid;
            end
            if (!out_vld_reg || out_ch.ready)
            begin
                out_vld_reg <= advance && produce;
            end
            if (advance)
            begin
                phase_reg   <= phase_next;
                hdr_idx_reg <= hdr_idx_next;
                len_reg     <= len_next;
                left_reg    <= left_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_mode_reg <= in_ch.mode;
            in_byte_reg <= in_ch.data_byte;
        end
        if (advance && produce)
        begin
            out_byte_reg <= res_byte;
            out_last_reg <= res_last;
            out_err_reg  <= res_err;
        end
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.payload_byte   = out_byte_reg;
    assign out_ch.last_in_packet = out_last_reg;
    assign out_ch.length_error   = out_err_reg;

endmodule

@@ tb/length_prefix_deframer_core_tb.sv @@
// length_prefix_deframer_core_tb: self-checking bench for the length-prefix deframer
// streams byte words through in_ch, predicts each out_ch word and checks it field by field
// depends on lpd_pkg, lpd_in_if / lpd_out_if and length_prefix_deframer_core
module length_prefix_deframer_core_tb;
    import lpd_pkg::*;

    localparam int HDR_BYTES = 4;
    localparam logic [APB_ADDR_W-1:0] MAX_LEN_ADDR = APB_ADDR_W'(4 * REG_MAX_LEN);
    localparam int MAX_GAP = 17;
    localparam int LONG_HOLD = 150;
    localparam int DRAIN_CYCLES = 8;

    // one word offered on in_ch
    typedef struct packed {
        logic       mode;
        logic [7:0] data;
    } rx_word_t;

    // one word expected on out_ch
    typedef struct packed {
        logic [7:0] payload;
        logic       last;
        logic       err;
    } frame_out_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    lpd_in_if  in_ch ();
    lpd_out_if out_ch ();

    length_prefix_deframer_core #(
        .HEADER_BYTES (HDR_BYTES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // stimulus and expectations
    rx_word_t   pending_rx_words[$];
    frame_out_t expected_out_words[$];
    int         words_pushed;
    int         words_accepted;
    int         fail_count;

    // deframer state as the bench sees it
    logic [1:0]           frm_phase;
    logic [1:0]           hdr_count;
    logic [31:0]          hdr_length;
    logic [MAX_LEN_W-1:0] payload_left;
    logic [MAX_LEN_W-1:0] max_len_model;

    // flow control knobs shared between the driver, the monitor and the ready process
    int   tx_gap;
    int   rx_gap;
    bit   tx_burst;
    bit   rx_burst;
    bit   tx_no_gaps;
    bit   in_taken;
    int   hold_request;
    int   hold_left;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // per-word wait, with occasional switches into stretches of back-to-back words
    function automatic int draw_gap(ref bit burst);
        if ($urandom_range(0, 29) == 0)
            burst = ~burst;
        return burst ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // advance the deframer state by one accepted word and queue any output it causes
    function automatic void deframe_step(logic mode, logic [7:0] b);
        frame_out_t res;
        if (mode)
        begin
            // new connection wipes framing but keeps the register
            frm_phase    = PH_HEADER;
            hdr_count    = '0;
            hdr_length   = '0;
            payload_left = '0;
            return;
        end
        case (frm_phase)
            PH_DROP:
            begin
                // after a bad header everything is swallowed
            end
            PH_PAYLOAD:
            begin
                payload_left = payload_left - 1'b1;
                res.payload  = b;
                res.last     = (payload_left == '0);
                res.err      = 1'b0;
                expected_out_words.push_back(res);
                if (res.last)
                begin
                    frm_phase  = PH_HEADER;
                    hdr_count  = '0;
                    hdr_length = '0;
                end
            end
            default:
            begin
                // header phase, little-endian length gathering
                hdr_length = hdr_length | (32'(b) << (8 * hdr_count));
                if (int'(hdr_count) + 1 < HDR_BYTES)
                begin
                    hdr_count = hdr_count + 1'b1;
                end
                else
                begin
                    hdr_count = '0;
                    if (hdr_length == '0 || hdr_length > 32'(max_len_model))
                    begin
                        frm_phase   = PH_DROP;
                        res.payload = '0;
                        res.last    = 1'b0;
                        res.err     = 1'b1;
                        expected_out_words.push_back(res);
                    end
                    else
                    begin
                        payload_left = hdr_length[MAX_LEN_W-1:0];
                        frm_phase    = PH_PAYLOAD;
                    end
                end
            end
        endcase
    endfunction

    // input driver: presents queued words, holds each until taken, inserts random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid || in_taken)
        begin
            in_taken = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap = tx_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_rx_words.size() > 0)
            begin
                in_ch.valid     <= 1'b1;
                in_ch.mode      <= pending_rx_words[0].mode;
                in_ch.data_byte <= pending_rx_words[0].data;
                void'(pending_rx_words.pop_front());
                tx_gap = tx_no_gaps ? 0 : draw_gap(tx_burst);
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // output ready: a long hold when requested, else a random wait after each word
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap = rx_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // monitor: check outputs against the oldest expectation, then predict from the input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_out_words.size() == 0)
                begin
                    $error("unexpected word: payload_byte %0h last_in_packet %0b length_error %0b",
                           out_ch.payload_byte, out_ch.last_in_packet, out_ch.length_error);
                    fail_count++;
                end
                else
                begin
                    if (out_ch.payload_byte !== expected_out_words[0].payload)
                    begin
                        $error("payload_byte: expected %0h, got %0h",
                               expected_out_words[0].payload, out_ch.payload_byte);
                        fail_count++;
                    end
                    if (out_ch.last_in_packet !== expected_out_words[0].last)
                    begin
                        $error("last_in_packet: expected %0b, got %0b",
                               expected_out_words[0].last, out_ch.last_in_packet);
                        fail_count++;
                    end
                    if (out_ch.length_error !== expected_out_words[0].err)
                    begin
                        $error("length_error: expected %0b, got %0b",
                               expected_out_words[0].err, out_ch.length_error);
                        fail_count++;
                    end
                    void'(expected_out_words.pop_front());
                end
                rx_gap = draw_gap(rx_burst);
            end
            if (in_ch.valid && in_ch.ready)
            begin
                deframe_step(in_ch.mode, in_ch.data_byte);
                in_taken = 1'b1;
                words_accepted++;
            end
        end
    end

    task automatic push_word(input logic mode, input logic [7:0] b);
        rx_word_t w;
        w.mode = mode;
        w.data = b;
        pending_rx_words.push_back(w);
        words_pushed++;
    endtask

    // length header, least significant byte first
    task automatic push_header(input logic [31:0] len);
        for (int i = 0; i < HDR_BYTES; i++)
            push_word(1'b0, len[8*i +: 8]);
    endtask

    // header plus the first n_bytes of its payload, random content
    task automatic push_frame(input logic [31:0] len, input int n_bytes);
        push_header(len);
        repeat (n_bytes)
            push_word(1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_reconnect();
        push_word(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // wait until every word is taken and every output seen, then let the pipe settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (words_accepted != words_pushed || expected_out_words.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // apb write of max_packet_length, then read it back
    task automatic write_max_len(input logic [31:0] value);
        logic [APB_DATA_W-1:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_LEN_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        max_len_model = value[MAX_LEN_W-1:0];
        @(negedge clk);
        psel    <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[MAX_LEN_W-1:0] !== max_len_model)
        begin
            $error("max_packet_length: expected %0d, got %0d", max_len_model,
                   rd[MAX_LEN_W-1:0]);
            fail_count++;
        end
    endtask

    // frames right at the limit and one past it
    task automatic push_boundary_frames();
        if (max_len_model != '0)
        begin
            if (max_len_model <= 40)
            begin
                push_frame(32'(max_len_model), int'(max_len_model));
            end
            else
            begin
                // too long to send whole, so cut it short with a new connection
                push_frame(32'(max_len_model), 10);
                push_reconnect();
            end
        end
        push_header(32'(max_len_model) + 1);
        push_word(1'b0, 8'($urandom_range(0, 255)));
        push_reconnect();
    endtask

    // mostly well-formed frames with random content, plus bad headers, aborts and noise
    task automatic push_traffic(input int n_words);
        int          start;
        int          kind;
        int          hi;
        int          len;
        logic [31:0] v;
        start = words_pushed;
        hi = (max_len_model < 12) ? int'(max_len_model) : 12;
        while (words_pushed - start < n_words)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65 && hi > 0)
            begin
                len = $urandom_range(1, hi);
                push_frame(32'(len), len);
            end
            else if (kind < 77 || hi == 0)
            begin
                // bad header: zero or over the limit, then a few dropped bytes
                if ($urandom_range(0, 2) == 0)
                begin
                    v = '0;
                end
                else
                begin
                    v = $urandom;
                    if (v <= 32'(max_len_model))
                        v = 32'(max_len_model) + 32'($urandom_range(1, 3));
                end
                push_frame(v, $urandom_range(0, 3));
                push_reconnect();
            end
            else if (kind < 87)
            begin
                // new connection in the middle of a header or a payload
                if (hi < 2 || $urandom_range(0, 1) == 0)
                begin
                    repeat ($urandom_range(1, HDR_BYTES - 1))
                        push_word(1'b0, 8'($urandom_range(0, 255)));
                end
                else
                begin
                    len = $urandom_range(2, hi);
                    push_frame(32'(len), $urandom_range(1, len - 1));
                end
                push_reconnect();
            end
            else if (kind < 95)
            begin
                push_reconnect();
            end
            else
            begin
                // raw noise, then resync
                repeat ($urandom_range(1, 4))
                    push_word(1'b0, 8'($urandom_range(0, 255)));
                push_reconnect();
            end
        end
    endtask

    // run control
    initial
    begin
        logic [31:0] cfg_values[6];

        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = 1'b0;
        in_ch.data_byte = '0;
        out_ch.ready    = 1'b0;
        words_pushed    = 0;
        words_accepted  = 0;
        fail_count      = 0;
        tx_gap          = 0;
        rx_gap          = 0;
        tx_burst        = 1'b0;
        rx_burst        = 1'b0;
        tx_no_gaps      = 1'b0;
        in_taken        = 1'b0;
        hold_request    = 0;
        hold_left       = 0;
        frm_phase       = PH_HEADER;
        hdr_count       = '0;
        hdr_length      = '0;
        payload_left    = '0;
        max_len_model   = MAX_LEN_RESET;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed: shortest frames, byte extremes, bad headers, aborts
        push_frame(32'd1, 0);
        push_word(1'b0, 8'h00);
        push_header(32'd2);
        push_word(1'b0, 8'hFF);
        push_word(1'b0, 8'h80);
        // zero length, then bytes that must be dropped
        push_header(32'd0);
        push_word(1'b0, 8'hFF);
        push_word(1'b0, 8'h00);
        push_word(1'b1, 8'hFF);
        // one past the reset limit
        push_header(32'h0020_0001);
        push_word(1'b1, 8'h00);
        // new connection inside a header
        push_word(1'b0, 8'h03);
        push_word(1'b0, 8'hFF);
        push_reconnect();
        // new connection inside a payload
        push_header(32'd3);
        push_word(1'b0, 8'h5A);
        push_reconnect();
        wait_drained();

        // register sweep: small, zero, minimum, all ones, random, reset value
        cfg_values[0] = 32'd5;
        cfg_values[1] = 32'd0;
        cfg_values[2] = 32'd1;
        cfg_values[3] = 32'hFFFF_FFFF;
        cfg_values[4] = 32'($urandom_range(2, 300));
        cfg_values[5] = 32'd2097152;
        for (int p = 0; p < 6; p++)
        begin
            write_max_len(cfg_values[p]);
            push_boundary_frames();
            if (p == 0)
            begin
                // back up the output with a long stall while input keeps coming
                wait_drained();
                tx_no_gaps = 1'b1;
                @(posedge clk);
                hold_request = LONG_HOLD;
                push_traffic(40);
                wait_drained();
                tx_no_gaps = 1'b0;
            end
            push_traffic(45);
            wait_drained();
        end

        if (fail_count == 0)
            $display("** length_prefix_deframer_core: PASSED **");
        else
            $display("** length_prefix_deframer_core: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("** length_prefix_deframer_core: FAILED **");
        $finish;
    end

endmodule

@@ length_prefix_deframer_core.f @@
sv/lpd_pkg.sv
sv/lpd_if.sv
sv/lpd_apb_regs.sv
sv/length_prefix_deframer_core.sv
tb/length_prefix_deframer_core_tb.sv
